@@ rtl/dcs_pkg.sv @@
// Shared types and field widths of the distinct-count sketch.
package dcs_pkg;

  localparam int unsigned HASH_W  = 64;
  localparam int unsigned TRIAL_W = 4;
  localparam int unsigned RANK_W  = 7;
  localparam int unsigned SUM_W   = 11;
  localparam int unsigned EST_W   = 64;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [HASH_W-1:0]  hash_value;
    logic [TRIAL_W-1:0] trial;
  } item_t;

endpackage

@@ rtl/dcs_update.sv @@
// Trial bitmaps, per-trial ranks and the running rank total.
module dcs_update #(
  parameter int unsigned TRIALS = 16,
  localparam int unsigned TotalW = $clog2(64 * TRIALS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  dcs_pkg::item_t      item_i,
  output logic [TotalW-1:0]   total_o
);

  localparam int unsigned IdxW = (TRIALS > 1) ? $clog2(TRIALS) : 1;
  localparam int unsigned ExtW = (IdxW > dcs_pkg::TRIAL_W) ? IdxW : dcs_pkg::TRIAL_W;

  function automatic logic [dcs_pkg::RANK_W-1:0] trailing_ones(
    logic [dcs_pkg::HASH_W-1:0] b
  );
    logic [dcs_pkg::HASH_W-1:0] zeros;
    logic [dcs_pkg::HASH_W-1:0] first;
    logic [dcs_pkg::RANK_W-2:0] pos;
    zeros = ~b;
    first = zeros & (~zeros + 1'b1);
    pos   = '0;
    for (int n = 0; n < dcs_pkg::HASH_W; n++) begin
      if (first[n]) begin
        pos = pos | (dcs_pkg::RANK_W-1)'(n);
      end
    end
    if (zeros == '0) begin
      return dcs_pkg::RANK_W'(dcs_pkg::HASH_W);
    end
    return {1'b0, pos};
  endfunction

  logic [dcs_pkg::HASH_W-1:0] bitmaps_q [TRIALS];
  logic [dcs_pkg::RANK_W-1:0] ranks_q   [TRIALS];
  logic [TotalW-1:0]          total_q, total_d;

  logic [ExtW-1:0]            trial_ext;
  logic [IdxW-1:0]            idx;
  logic                       in_range;
  logic [dcs_pkg::HASH_W-1:0] low_bit;
  logic [dcs_pkg::HASH_W-1:0] bitmap_d;
  logic [dcs_pkg::RANK_W-1:0] rank_d;
  logic                       do_insert;
  logic                       do_clear;

  assign trial_ext = ExtW'(item_i.trial);
  assign idx       = trial_ext[IdxW-1:0];
  assign in_range  = 32'(item_i.trial) < 32'(TRIALS);
  assign low_bit   = item_i.hash_value & (~item_i.hash_value + 1'b1);
  assign bitmap_d  = bitmaps_q[idx] | low_bit;
  assign rank_d    = trailing_ones(bitmap_d);
  assign total_d   = total_q + TotalW'(rank_d) - TotalW'(ranks_q[idx]);
  assign do_clear  = en_i && (item_i.op == dcs_pkg::OP_CLEAR);
  assign do_insert = en_i && (item_i.op == dcs_pkg::OP_INSERT) && in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TRIALS; i++) begin
        bitmaps_q[i] <= '0;
        ranks_q[i]   <= '0;
      end
      total_q <= '0;
    end else if (do_clear) begin
      for (int i = 0; i < TRIALS; i++) begin
        bitmaps_q[i] <= '0;
        ranks_q[i]   <= '0;
      end
      total_q <= '0;
    end else if (do_insert) begin
      bitmaps_q[idx] <= bitmap_d;
      ranks_q[idx]   <= rank_d;
      total_q        <= total_d;
    end
  end

  assign total_o = total_q;

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_clear |=> total_q == '0)
    else $error("rank total not zero after clear");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> total_q >= $past(total_q))
    else $error("rank total fell on insert");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(total_q))
    else $error("rank total moved without an update");

endmodule

@@ rtl/dcs_estimate.sv @@
// Rank total to saturated rank sum and fixed-point distinct-count estimate.
module dcs_estimate #(
  parameter int unsigned TRIALS = 16,
  localparam int unsigned TotalW = $clog2(64 * TRIALS + 1)
) (
  input  logic [TotalW-1:0]         total_i,
  output logic [dcs_pkg::SUM_W-1:0] rank_sum_o,
  output logic [dcs_pkg::EST_W-1:0] estimate_o
);

  localparam int unsigned K        = $clog2(TRIALS);
  localparam int unsigned FW       = (K > 0) ? K : 1;
  localparam int unsigned MantW    = 33;
  localparam int unsigned DropW    = 23;
  localparam int unsigned WideW    = dcs_pkg::EST_W + DropW + 1;
  localparam int unsigned ShiftMax = WideW - MantW;
  localparam int unsigned ShW      = $clog2(ShiftMax + 1);
  localparam int unsigned SumMax   = (1 << dcs_pkg::SUM_W) - 1;

  function automatic logic [63:0] isqrt64(logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [MantW-1:0] frac_mant(int unsigned f, int unsigned k);
    logic [63:0] root;
    logic [63:0] m;
    logic [63:0] v;
    m    = 64'h8000_0000;
    root = isqrt64(64'h8000_0000_0000_0000);
    for (int unsigned i = 1; i <= 6; i++) begin
      if (i > 1) begin
        root = isqrt64(root << 31);
      end
      if ((i <= k) && (((f >> (k - i)) & 1) != 0)) begin
        m = (m * root) >> 31;
      end
    end
    v = (m * 64'd100000) / 64'd77351;
    return v[MantW-1:0];
  endfunction

  logic [MantW-1:0] vtab [TRIALS];

  for (genvar gi = 0; gi < TRIALS; gi++) begin : g_tab
    localparam logic [MantW-1:0] MantVal = frac_mant(gi, K);
    assign vtab[gi] = MantVal;
  end

  logic [FW-1:0]     f_idx;
  logic [TotalW-1:0] q;
  logic              q_over;
  logic [ShW-1:0]    sh;
  logic [WideW-1:0]  wide;

  assign f_idx  = (K == 0) ? '0 : total_i[FW-1:0];
  assign q      = total_i >> K;
  assign q_over = 32'(q) > 32'(ShiftMax);
  assign sh     = q[ShW-1:0];
  assign wide   = WideW'(vtab[f_idx]) << sh;

  assign estimate_o = (q_over || wide[WideW-1]) ? '1 : wide[WideW-2:DropW];
  assign rank_sum_o = (32'(total_i) > 32'(SumMax)) ? '1 : dcs_pkg::SUM_W'(total_i);

endmodule

@@ rtl/distinct_count_sketch.sv @@
// Top level of the distinct-count sketch: stream ports and the three-stage word pipeline.
//
// Input stream: one word per hashed value. tdata carries hash_value in bits 63:0
// and trial in bits 67:64; tuser carries op (0 insert, 1 clear all trials).
// Output stream: one word per input word, in order. tdata carries rank_sum in
// bits 10:0 (sum of the trailing-ones counts of all trial bitmaps, saturating)
// and estimate in bits 74:11 (2^(rank_sum/TRIALS)/0.77351, unsigned, 8 fraction
// bits, saturating at all ones).
// Each word's result is registered in turn by the input, update and output stages before it is valid.
// Throughput: one word per cycle unless the output stalls; the bitmap update and its
// rank count finish within the one update stage, so a word for the same trial may follow at once.
// Reset clears every bitmap and the rank total; no words are in flight after it.
// A stalled output holds its word; the input, update and output stages fill and
// the input deasserts tready only when all three are occupied.
// Trials at or above TRIALS are ignored on insert and report the current state.
module distinct_count_sketch #(
  parameter int unsigned TRIALS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // hash_value[63:0], trial[67:64], zero pad
  input  logic [0:0]  s_axis_tuser_i,   // op[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o    // rank_sum[10:0], estimate[74:11], zero pad
);

  localparam int unsigned TotalW = $clog2(64 * TRIALS + 1);

  dcs_pkg::item_t               in_q;
  logic                         in_vld_q, in_vld_d;
  logic                         upd_vld_q, upd_vld_d;
  logic                         out_vld_q, out_vld_d;
  logic [dcs_pkg::SUM_W-1:0]    rank_sum_q;
  logic [dcs_pkg::EST_W-1:0]    estimate_q;
  logic [dcs_pkg::SUM_W-1:0]    rank_sum;
  logic [dcs_pkg::EST_W-1:0]    estimate;
  logic [TotalW-1:0]            total;

  logic out_free;
  logic upd_free;
  logic upd_adv;
  logic in_adv;
  logic in_take;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign upd_free        = !upd_vld_q || out_free;
  assign upd_adv         = upd_vld_q && out_free;
  assign in_adv          = in_vld_q && upd_free;
  assign s_axis_tready_o = !in_vld_q || upd_free;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_vld_d  = in_take ? 1'b1 : (upd_free ? 1'b0 : in_vld_q);
    upd_vld_d = in_adv ? 1'b1 : (out_free ? 1'b0 : upd_vld_q);
    out_vld_d = upd_adv ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      upd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      upd_vld_q <= upd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.op         <= dcs_pkg::op_e'(s_axis_tuser_i[0]);
      in_q.hash_value <= s_axis_tdata_i[63:0];
      in_q.trial      <= s_axis_tdata_i[67:64];
    end
    if (upd_adv) begin
      rank_sum_q <= rank_sum;
      estimate_q <= estimate;
    end
  end

  dcs_update #(
    .TRIALS (TRIALS)
  ) u_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (in_adv),
    .item_i  (in_q),
    .total_o (total)
  );

  dcs_estimate #(
    .TRIALS (TRIALS)
  ) u_estimate (
    .total_i    (total),
    .rank_sum_o (rank_sum),
    .estimate_o (estimate)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'b0, estimate_q, rank_sum_q};

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (out_vld_q && !m_axis_tready_i && upd_vld_q && in_vld_q))
    else $error("input blocked without a full stalled pipeline");

  a_update_follows_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_vld_q && !$past(upd_vld_q) |-> $past(in_vld_q))
    else $error("update stage filled without an input word");

  a_output_follows_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(upd_vld_q))
    else $error("result appeared without an update");

endmodule
